// File: design/aas_pkg.sv
// Types and codes for the apnea alarm supervisor.
package aas_pkg;

	// Alarm state machine, one-hot
	typedef enum logic [4:0] {
		ALM_FALSE     = 5'b00001,
		ALM_DETECTED  = 5'b00010,
		ALM_TRUE      = 5'b00100,
		ALM_DISPLAYED = 5'b01000,
		ALM_CANCELED  = 5'b10000
	} alarm_fsm_t;

	// Alarm state codes as seen on the result port
	localparam logic [2:0] CODE_FALSE     = 3'd0;
	localparam logic [2:0] CODE_DETECTED  = 3'd1;
	localparam logic [2:0] CODE_TRUE      = 3'd2;
	localparam logic [2:0] CODE_DISPLAYED = 3'd3;
	localparam logic [2:0] CODE_CANCELED  = 3'd4;

	// Breath phase codes
	localparam logic [2:0] PH_DISABLED   = 3'd0;
	localparam logic [2:0] PH_EXHALATION = 3'd1;
	localparam logic [2:0] PH_TRIGGERED  = 3'd2;
	localparam logic [2:0] PH_CONTROLLED = 3'd3;

	// Event codes
	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_RAISE = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;

	// Configuration register indexes
	localparam logic CFG_APNEA_DELAY  = 1'b0;
	localparam logic CFG_CLEAR_CYCLES = 1'b1;

	localparam logic [15:0] APNEA_DELAY_RST  = 16'd20000;
	localparam logic [7:0]  CLEAR_CYCLES_RST = 8'd3;
	localparam logic [7:0]  BREATH_CNT_MAX   = 8'd255;

	function automatic logic [2:0] encode_state(alarm_fsm_t st);
		logic [2:0] code;
		case (st)
			ALM_FALSE:     code = CODE_FALSE;
			ALM_DETECTED:  code = CODE_DETECTED;
			ALM_TRUE:      code = CODE_TRUE;
			ALM_DISPLAYED: code = CODE_DISPLAYED;
			ALM_CANCELED:  code = CODE_CANCELED;
			default:       code = CODE_FALSE;
		endcase
		return code;
	endfunction

endpackage

// File: design/apnea_alarm_supervisor_top.sv
// Apnea alarm supervisor: alarm state machine, apnea countdown and breath counting.
//
// Usage:
//   One request on the req channel is one supervision period: breath phase,
//   timer tick, cancel key, uncancel command, CPAP mode and display acknowledge.
//   Each request gives exactly one response on the rsp channel: the alarm state
//   after the update, the priority bit and an event (none, raise, end).
//   Both channels use valid/ready; a transfer happens when both are high.
//   Configuration (apnea_delay at index 0, clear_cycles at index 1) is written via
//   cfg_we/cfg_index/cfg_data, no wait; the user must write only while idle (unenforced).
// Timing:
//   The request is registered; the state update runs combinationally from that register
//   into the response register. One request per cycle is sustained while rsp_ready
//   stays high; the state update loop sets that rate.
// Reset:
//   arst_n clears the alarm to the false state, countdown, previous phase,
//   breath count and priority to zero, apnea_delay to 20000, clear_cycles to 3.
// Stall:
//   When rsp_ready is low the response register holds; one more request waits
//   in the input register, then req_ready drops until the response is taken.
module apnea_alarm_supervisor_top
	import aas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  breath_phase,
	input  logic        tick,
	input  logic        cancel_key,
	input  logic        uncancel_cmd,
	input  logic        cpap_mode,
	input  logic        hmi_displayed,
	// response channel
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  alarm_state,
	output logic        priority_bit,
	output logic [1:0]  alarm_event
);

	// configuration registers
	logic [15:0] apnea_delay_q;
	logic [7:0]  clear_cycles_q;

	// supervision state
	alarm_fsm_t  status_q;
	logic [15:0] countdown_q;
	logic [2:0]  prev_phase_q;
	logic [7:0]  breath_cnt_q;
	logic        prio_q;

	// input register
	logic        valid_s1;
	logic [2:0]  phase_s1;
	logic        tick_s1;
	logic        cancel_s1;
	logic        uncancel_s1;
	logic        cpap_s1;
	logic        shown_s1;

	// result register
	logic        valid_s2;
	logic [2:0]  state_s2;
	logic        prio_s2;
	logic [1:0]  event_s2;

	logic        adv_s2;
	logic        adv_s1;

	// next-state logic
	alarm_fsm_t  status_d;
	logic [15:0] countdown_d;
	logic [7:0]  breath_cnt_d;
	logic        prio_d;
	logic [1:0]  event_d;
	logic [15:0] cd_ticked;
	logic        after_exh;
	logic        trig_breath;
	logic        ctrl_breath;
	logic [7:0]  cnt_brt;
	logic [15:0] cd_brt;
	logic        alarm_end;

	assign adv_s2    = valid_s1 && (!valid_s2 || rsp_ready);
	assign adv_s1    = req_valid && req_ready;
	assign req_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			apnea_delay_q  <= APNEA_DELAY_RST;
			clear_cycles_q <= CLEAR_CYCLES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_APNEA_DELAY:  apnea_delay_q  <= cfg_data;
				CFG_CLEAR_CYCLES: clear_cycles_q <= cfg_data[7:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			phase_s1    <= breath_phase;
			tick_s1     <= tick;
			cancel_s1   <= cancel_key;
			uncancel_s1 <= uncancel_cmd;
			cpap_s1     <= cpap_mode;
			shown_s1    <= hmi_displayed;
		end
	end

	// tick first, saturating at zero
	assign cd_ticked = (tick_s1 && (countdown_q != '0)) ? (countdown_q - 16'd1) : countdown_q;

	assign after_exh   = (prev_phase_q == PH_EXHALATION);
	assign trig_breath = after_exh && (phase_s1 == PH_TRIGGERED);
	assign ctrl_breath = after_exh && (phase_s1 == PH_CONTROLLED);

	// breath counting shared by displayed and canceled
	always_comb begin
		cnt_brt = breath_cnt_q;
		cd_brt  = cd_ticked;
		if (trig_breath) begin
			cd_brt = apnea_delay_q;
			if (breath_cnt_q != BREATH_CNT_MAX)
				cnt_brt = breath_cnt_q + 8'd1;
		end else if (ctrl_breath) begin
			cnt_brt = '0;
		end
	end

	assign alarm_end = (cnt_brt >= clear_cycles_q);

	always_comb begin
		status_d     = status_q;
		countdown_d  = cd_ticked;
		breath_cnt_d = breath_cnt_q;
		prio_d       = prio_q;
		event_d      = EV_NONE;
		case (status_q)
			ALM_DETECTED: begin
				if (cd_ticked == '0) begin
					status_d = ALM_TRUE;
					event_d  = EV_RAISE;
					prio_d   = 1'b1;
				end else if (trig_breath) begin
					status_d     = ALM_FALSE;
					breath_cnt_d = '0;
				end
			end
			ALM_TRUE: begin
				if (shown_s1)
					status_d = ALM_DISPLAYED;
			end
			ALM_DISPLAYED, ALM_CANCELED: begin
				countdown_d  = cd_brt;
				breath_cnt_d = cnt_brt;
				if (alarm_end) begin
					status_d     = ALM_FALSE;
					breath_cnt_d = '0;
					prio_d       = 1'b0;
					event_d      = EV_END;
				end else if (status_q == ALM_DISPLAYED) begin
					if (cancel_s1 && !cpap_s1) begin
						status_d = ALM_CANCELED;
						prio_d   = 1'b0;
					end
				end else if (uncancel_s1) begin
					status_d = ALM_TRUE;
					prio_d   = 1'b1;
				end
			end
			default: begin
				countdown_d = apnea_delay_q;
				status_d    = ALM_DETECTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= ALM_FALSE;
			countdown_q  <= '0;
			prev_phase_q <= PH_DISABLED;
			breath_cnt_q <= '0;
			prio_q       <= 1'b0;
		end else if (adv_s2) begin
			status_q     <= status_d;
			countdown_q  <= countdown_d;
			prev_phase_q <= phase_s1;
			breath_cnt_q <= breath_cnt_d;
			prio_q       <= prio_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			state_s2 <= encode_state(status_d);
			prio_s2  <= prio_d;
			event_s2 <= event_d;
		end
	end

	assign rsp_valid    = valid_s2;
	assign alarm_state  = state_s2;
	assign priority_bit = prio_s2;
	assign alarm_event  = event_s2;

`ifndef SYNTH
	// priority is lit exactly while the alarm is true or displayed
	a_prio_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		prio_q == ((status_q == ALM_TRUE) || (status_q == ALM_DISPLAYED)))
		else $error("priority flag out of step with alarm state");

	// a raise event reports a true alarm with priority set
	a_raise_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (alarm_event == EV_RAISE)) |-> ((alarm_state == CODE_TRUE) && priority_bit))
		else $error("raise event without true alarm and priority");

	// an end event reports a false alarm with priority cleared
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (alarm_event == EV_END)) |-> ((alarm_state == CODE_FALSE) && !priority_bit))
		else $error("end event without cleared alarm");

	// a false alarm always rearms into detected on the next request
	a_false_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && (status_q == ALM_FALSE)) |=> ((status_q == ALM_DETECTED)
			&& (countdown_q == $past(apnea_delay_q))))
		else $error("false state did not rearm countdown");
`endif

endmodule

// File: sim/apnea_alarm_supervisor_top_tb.sv
// Testbench for the apnea alarm supervisor: directed paths, register extremes and random episodes.
`timescale 1ns / 100ps

module apnea_alarm_supervisor_top_tb;
	import aas_pkg::*;

	localparam logic [2:0] PH_OTHER    = 3'd4;
	localparam logic [2:0] PH_SPARE_LO = 3'd5;
	localparam logic [2:0] PH_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [2:0] state;
		logic       prio;
		logic [1:0] ev;
	} alarm_outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_APNEA_DELAY;
	logic [15:0] cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [2:0]  breath_phase = PH_DISABLED;
	logic        tick = 1'b0;
	logic        cancel_key = 1'b0;
	logic        uncancel_cmd = 1'b0;
	logic        cpap_mode = 1'b0;
	logic        hmi_displayed = 1'b0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic [2:0]  alarm_state;
	logic        priority_bit;
	logic [1:0]  alarm_event;

	// shadow of the supervisor state and registers
	logic [2:0]  alarm_code;
	logic [15:0] apnea_timer;
	logic [2:0]  last_phase;
	logic [7:0]  breath_tally;
	logic        prio_led;
	logic [15:0] reload_ticks;
	logic [7:0]  end_breaths;

	alarm_outcome_t alarm_outcomes_due[$];
	alarm_outcome_t due;

	int unsigned mismatches = 0;
	int unsigned periods_sent = 0;
	int unsigned responses_seen = 0;
	int unsigned raises_seen = 0;
	int unsigned ends_seen = 0;
	int unsigned burst_left = 0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;

	apnea_alarm_supervisor_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.breath_phase (breath_phase),
		.tick         (tick),
		.cancel_key   (cancel_key),
		.uncancel_cmd (uncancel_cmd),
		.cpap_mode    (cpap_mode),
		.hmi_displayed(hmi_displayed),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.alarm_state  (alarm_state),
		.priority_bit (priority_bit),
		.alarm_event  (alarm_event)
	);

	always #10 clk = ~clk;

	function automatic logic one_in(int unsigned n);
		return $urandom_range(1, n) == 1;
	endfunction

	// Breath counting while displayed or canceled; returns 1 when the alarm ends.
	function automatic logic tally_breaths(logic [2:0] phase);
		logic after_exh;
		after_exh = (last_phase == PH_EXHALATION);
		if (phase == PH_TRIGGERED && after_exh) begin
			apnea_timer = reload_ticks;
			if (breath_tally < BREATH_CNT_MAX)
				breath_tally++;
		end else if (phase == PH_CONTROLLED && after_exh) begin
			breath_tally = '0;
		end
		if (breath_tally >= end_breaths) begin
			alarm_code = CODE_FALSE;
			breath_tally = '0;
			prio_led = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic alarm_outcome_t step_alarm(logic [2:0] phase, logic tk, logic cancel,
		logic uncancel, logic cpap, logic shown);
		alarm_outcome_t o;
		o.ev = EV_NONE;
		// tick is applied before the state update, saturating at zero
		if (tk && apnea_timer != 0)
			apnea_timer--;
		case (alarm_code)
			CODE_DETECTED: begin
				if (apnea_timer == 0) begin
					alarm_code = CODE_TRUE;
					o.ev = EV_RAISE;
					prio_led = 1'b1;
				end else if (phase == PH_TRIGGERED && last_phase == PH_EXHALATION) begin
					alarm_code = CODE_FALSE;
					breath_tally = '0;
				end
			end
			CODE_TRUE: begin
				if (shown)
					alarm_code = CODE_DISPLAYED;
			end
			CODE_DISPLAYED: begin
				if (tally_breaths(phase)) begin
					o.ev = EV_END;
				end else if (cancel && !cpap) begin
					alarm_code = CODE_CANCELED;
					prio_led = 1'b0;
				end
			end
			CODE_CANCELED: begin
				if (tally_breaths(phase)) begin
					o.ev = EV_END;
				end else if (uncancel) begin
					alarm_code = CODE_TRUE;
					prio_led = 1'b1;
				end
			end
			default: begin
				apnea_timer = reload_ticks;
				alarm_code = CODE_DETECTED;
			end
		endcase
		last_phase = phase;
		o.state = alarm_code;
		o.prio = prio_led;
		return o;
	endfunction

	// One supervision period; returns at the edge where it was accepted.
	task automatic send_period(logic [2:0] phase, logic tk, logic cancel, logic uncancel,
		logic cpap, logic shown);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = one_in(4) ? 0 : $urandom_range(1, 5);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid     <= 1'b1;
		breath_phase  <= phase;
		tick          <= tk;
		cancel_key    <= cancel;
		uncancel_cmd  <= uncancel;
		cpap_mode     <= cpap;
		hmi_displayed <= shown;
		do
			@(posedge clk);
		while (!req_ready);
		alarm_outcomes_due.push_back(step_alarm(phase, tk, cancel, uncancel, cpap, shown));
		periods_sent++;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (alarm_outcomes_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_register(logic idx, logic [15:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_APNEA_DELAY)
			reload_ticks = value;
		else
			end_breaths = value[7:0];
	endtask

	task automatic check_field(string what, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, what, exp_v, act_v);
			mismatches++;
		end
	endtask

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (alarm_outcomes_due.size() == 0) begin
				$display("%0t response with no request pending: expected none actual %0d/%0d/%0d",
					$time, alarm_state, priority_bit, alarm_event);
				mismatches++;
			end else begin
				due = alarm_outcomes_due.pop_front();
				check_field("alarm_state", due.state, alarm_state);
				check_field("priority_bit", due.prio, priority_bit);
				check_field("alarm_event", due.ev, alarm_event);
				responses_seen++;
				if (due.ev == EV_RAISE)
					raises_seen++;
				if (due.ev == EV_END)
					ends_seen++;
			end
		end
	end

	// receiver backpressure: runs of always-ready, light, heavy and alternating stalls
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(8, 60);
		end
		stall_left--;
		case (stall_mode)
			0:       rsp_ready <= 1'b1;
			1:       rsp_ready <= !one_in(4);
			2:       rsp_ready <= one_in(4);
			default: rsp_ready <= stall_left[0];
		endcase
	end

	task automatic test_alarm_paths();
		set_register(CFG_APNEA_DELAY, 16'd2);
		set_register(CFG_CLEAR_CYCLES, 16'd2);
		send_period(PH_DISABLED,   0, 0, 0, 0, 0);
		send_period(PH_EXHALATION, 1, 0, 0, 0, 1);
		send_period(PH_TRIGGERED,  1, 0, 0, 0, 0); // raise wins over the breath
		send_period(PH_OTHER,      0, 1, 1, 0, 0);
		send_period(PH_SPARE_HI,   0, 0, 0, 0, 1);
		send_period(PH_EXHALATION, 0, 1, 0, 1, 0); // cancel blocked in CPAP
		send_period(PH_TRIGGERED,  1, 0, 0, 0, 0);
		send_period(PH_EXHALATION, 0, 0, 0, 0, 0);
		send_period(PH_CONTROLLED, 0, 0, 0, 0, 0); // controlled breath clears the count
		send_period(PH_EXHALATION, 0, 1, 0, 0, 0);
		send_period(PH_TRIGGERED,  0, 0, 1, 0, 0); // uncancel, no event
		send_period(PH_SPARE_LO,   0, 0, 0, 0, 1);
		send_period(PH_EXHALATION, 0, 1, 0, 0, 0);
		send_period(PH_TRIGGERED,  0, 0, 0, 0, 0); // end of apnea
		send_period(PH_SPARE_HI,   0, 0, 0, 0, 0);
		send_period(PH_EXHALATION, 1, 0, 0, 0, 0);
		send_period(PH_TRIGGERED,  0, 0, 0, 0, 0); // breath while detected drops to false
		send_period(PH_SPARE_HI,   1, 1, 1, 1, 1);
	endtask

	task automatic test_register_extremes();
		set_register(CFG_APNEA_DELAY, 16'd0);
		set_register(CFG_CLEAR_CYCLES, 16'd0);
		send_period(PH_OTHER, 1, 0, 0, 0, 0);
		send_period(PH_OTHER, 1, 0, 0, 0, 0);
		send_period(PH_OTHER, 0, 0, 0, 0, 1);
		send_period(PH_OTHER, 0, 0, 0, 0, 0); // zero clear count ends at once
		send_period(PH_OTHER, 0, 0, 0, 0, 0);
		send_period(PH_OTHER, 0, 0, 0, 0, 0);
		set_register(CFG_APNEA_DELAY, 16'hFFFF);
		set_register(CFG_CLEAR_CYCLES, 16'd255);
		send_period(PH_OTHER,      0, 0, 0, 0, 1);
		send_period(PH_EXHALATION, 1, 0, 0, 0, 0);
		send_period(PH_TRIGGERED,  1, 0, 0, 0, 0);
		send_period(PH_EXHALATION, 1, 0, 0, 0, 0);
	endtask

	task automatic random_phase_noise_free(output logic [2:0] ph);
		ph = one_in(3) ? PH_DISABLED : 3'($urandom_range(PH_OTHER, PH_SPARE_HI));
	endtask

	// Mostly well-formed apnea episodes: silence until the alarm raises, acknowledge,
	// then breathing that ends it; with cancel traffic and some fully random periods.
	task automatic run_episodes(int unsigned quota);
		int unsigned first, n, k;
		logic [2:0] ph;
		first = periods_sent;
		send_period(PH_EXHALATION, 0, 0, 0, 0, 0);
		send_period(PH_TRIGGERED, 0, 0, 0, 0, 0);
		while (periods_sent - first < quota) begin
			if (one_in(5)) begin
				n = $urandom_range(1, 6);
				repeat (n)
					send_period(3'($urandom_range(0, 7)), one_in(2), one_in(2), one_in(2),
						one_in(2), one_in(2));
			end else begin
				n = (reload_ticks > 12) ? 12 : reload_ticks + $urandom_range(1, 4);
				repeat (n) begin
					random_phase_noise_free(ph);
					send_period(ph, !one_in(10), one_in(8), one_in(10), one_in(2), one_in(8));
				end
				n = $urandom_range(1, 3);
				repeat (n) begin
					random_phase_noise_free(ph);
					send_period(ph, one_in(2), one_in(4), one_in(6), one_in(2), !one_in(3));
				end
				n = end_breaths + $urandom_range(0, 2);
				if (n > 10)
					n = 10;
				for (k = 0; k < n; k++) begin
					send_period(PH_EXHALATION, one_in(2), one_in(4), one_in(5), one_in(2),
						one_in(4));
					if (one_in(5))
						ph = PH_CONTROLLED;
					else if (one_in(10))
						random_phase_noise_free(ph);
					else
						ph = PH_TRIGGERED;
					send_period(ph, one_in(2), one_in(4), one_in(5), one_in(2), one_in(4));
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		set_register(CFG_APNEA_DELAY, 16'd0);
		set_register(CFG_CLEAR_CYCLES, 16'd1);
		run_episodes(140);
		set_register(CFG_APNEA_DELAY, 16'($urandom_range(1, 3)));
		set_register(CFG_CLEAR_CYCLES, 16'($urandom_range(1, 3)));
		run_episodes(150);
		set_register(CFG_APNEA_DELAY, 16'($urandom_range(4, 9)));
		set_register(CFG_CLEAR_CYCLES, 16'($urandom_range(2, 5)));
		run_episodes(150);
		set_register(CFG_APNEA_DELAY, 16'($urandom_range(0, 6)));
		set_register(CFG_CLEAR_CYCLES, 16'($urandom_range(1, 8)));
		run_episodes(150);
	endtask

	initial begin
		alarm_code   = CODE_FALSE;
		apnea_timer  = '0;
		last_phase   = PH_DISABLED;
		breath_tally = '0;
		prio_led     = 1'b0;
		reload_ticks = APNEA_DELAY_RST;
		end_breaths  = CLEAR_CYCLES_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alarm_paths();
		test_register_extremes();
		test_random_traffic();
		settle();
		repeat (8) @(posedge clk);
		$display("sent %0d periods, checked %0d responses", periods_sent, responses_seen);
		$display("alarm raises %0d, alarm ends %0d", raises_seen, ends_seen);
		if (mismatches == 0) begin
			$display("apnea_alarm_supervisor_top_tb: clean");
		end else begin
			$display("apnea_alarm_supervisor_top_tb: errors");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout with %0d responses outstanding", alarm_outcomes_due.size());
		$display("apnea_alarm_supervisor_top_tb: errors");
		$finish;
	end

endmodule

// File: sim.f
design/aas_pkg.sv
design/apnea_alarm_supervisor_top.sv
sim/apnea_alarm_supervisor_top_tb.sv
